@@ rtl/assert_macros.svh @@
// Assertion helper macros used by the scheduler table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ rtl/wfst_pkg.sv @@
// ----------------------------------------------------------------------------
// wfst_pkg
// Types, constants and the nice-to-weight table of the scheduler table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package wfst_pkg;
   localparam int DEFAULT_ENTRIES = 64;
   localparam logic [30:0] VR_MAX = 31'h7FFF_FFFF;
   localparam logic [15:0] EPOCH_MAX = 16'hFFFF;
   localparam logic [5:0] NICE_MAX = 6'd39;
   localparam logic [5:0] NICE_RESET = 6'd20;
   localparam logic [22:0] TW_MAX = 23'h7F_FFFF;

   localparam logic [2:0] CMD_CREATE = 3'd0;
   localparam logic [2:0] CMD_FORK = 3'd1;
   localparam logic [2:0] CMD_NICE = 3'd2;
   localparam logic [2:0] CMD_CHARGE = 3'd3;
   localparam logic [2:0] CMD_RUN = 3'd4;
   localparam logic [2:0] CMD_PICK = 3'd5;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_BAD_NICE = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [5:0]  slot;
      logic [5:0]  parent_slot;
      logic [5:0]  nice_value;
      logic [30:0] run_delta;
      logic        runnable_flag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  chosen_slot;
      logic [22:0] weight_sum;
   } rsp_type;

   // one table entry
   typedef struct packed {
      logic        used;
      logic        runnable;
      logic [5:0]  nice;
      logic [16:0] weight;
      logic [30:0] vrt;
      logic [15:0] epoch;
   } entry_type;

   function automatic logic [16:0] nice_weight(input logic [5:0] n);
      logic [16:0] w;
      case (n)
         6'd0: w = 17'd88818;  6'd1: w = 17'd71054;  6'd2: w = 17'd56843;
         6'd3: w = 17'd45475;  6'd4: w = 17'd36380;  6'd5: w = 17'd29104;
         6'd6: w = 17'd23283;  6'd7: w = 17'd18626;  6'd8: w = 17'd14901;
         6'd9: w = 17'd11921;  6'd10: w = 17'd9537;  6'd11: w = 17'd7629;
         6'd12: w = 17'd6104;  6'd13: w = 17'd4883;  6'd14: w = 17'd3906;
         6'd15: w = 17'd3125;  6'd16: w = 17'd2500;  6'd17: w = 17'd2000;
         6'd18: w = 17'd1600;  6'd19: w = 17'd1280;  6'd20: w = 17'd1024;
         6'd21: w = 17'd819;   6'd22: w = 17'd655;   6'd23: w = 17'd524;
         6'd24: w = 17'd419;   6'd25: w = 17'd336;   6'd26: w = 17'd268;
         6'd27: w = 17'd214;   6'd28: w = 17'd172;   6'd29: w = 17'd137;
         6'd30: w = 17'd110;   6'd31: w = 17'd88;    6'd32: w = 17'd70;
         6'd33: w = 17'd56;    6'd34: w = 17'd45;    6'd35: w = 17'd36;
         6'd36: w = 17'd29;    6'd37: w = 17'd23;    6'd38: w = 17'd18;
         default: w = 17'd15;
      endcase
      return w;
   endfunction
endpackage
`default_nettype wire

@@ rtl/weighted_fair_scheduler_table.sv @@
// ----------------------------------------------------------------------------
// weighted_fair_scheduler_table
// Ring of table cells with a sequencer that runs one command at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer (valid/stall). rsp_* returns exactly
//   one result per command; the block holds rsp_valid until rsp_stall drops.
//   csr_* writes default_nice; write only while the block is idle.
// Operation: the entries sit in a ring of TABLE_ENTRIES cells that rotates
//   by one position a cycle while a command scans or writes. A command makes
//   one full rotation to fetch the slot and parent entry (and, on pick, to sum
//   weights and find the minimum), then a second rotation that rewrites the
//   target entry as it passes the head. Charge runs the divider between them.
// Flow: one command at a time; req_stall is high from acceptance until the
//   result transfers.
// Reset: clears all used and runnable flags at once, default_nice to 20.
// A stalled receiver holds the result and the block takes no new command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module weighted_fair_scheduler_table #(
   parameter int TABLE_ENTRIES = wfst_pkg::DEFAULT_ENTRIES
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wfst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output wfst_pkg::rsp_type rsp_data,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire [5:0]         csr_data
);
   import wfst_pkg::*;
   localparam int PW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV, S_WRITE, S_RESP} state_type;

   state_type   state_ff;
   req_type     req_ff;
   logic [5:0]  dnice_ff;
   logic [CW-1:0] cnt_ff;
   logic [PW-1:0] pos_ff;   // slot index at the ring head
   entry_type   tgt_ff, par_ff;
   logic [23:0] tot_ff;
   logic        found_ff;
   logic [5:0]  best_ff;
   logic [15:0] bep_ff;
   logic [30:0] bvr_ff;
   rsp_type     rsp_ff;
   logic        rsp_v_ff;
   entry_type   new_ff;
   logic        wr_ff;    // write new_ff into the target on its pass
   logic [41:0] csum_ff;  // vruntime plus charged quotient
   logic        s_ok, p_ok;

   entry_type ring [TABLE_ENTRIES];
   entry_type head_in;
   logic      shift;
   assign shift = (state_ff == S_SCAN) || (state_ff == S_WRITE);

   genvar g;
   generate
      for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
         wfst_cell u_cell (
            .clock(clock), .reset(reset), .shift(shift),
            .d_in((g == TABLE_ENTRIES - 1) ? head_in : ring[g + 1]),
            .d_out(ring[g])
         );
      end
   endgenerate

   // ring[0] is the head; it recirculates to the tail, rewritten on match
   always_comb begin
      head_in = ring[0];
      if (state_ff == S_WRITE && wr_ff && s_ok && 9'(pos_ff) == 9'(req_ff.slot))
         head_in = new_ff;
   end

   assign s_ok = {3'b000, req_ff.slot} < 9'(TABLE_ENTRIES);
   assign p_ok = {3'b000, req_ff.parent_slot} < 9'(TABLE_ENTRIES);

   // divider for charge, started once the target entry has been captured
   logic        div_start, div_done;
   logic [40:0] div_q;
   assign div_start = (state_ff == S_DIV) && (cnt_ff == '0);
   wfst_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .delta(req_ff.run_delta), .weight(tgt_ff.weight),
      .done(div_done), .quot(div_q)
   );

   // fold the sum at bit 31: 2^31 = VR_MAX + 1, so sum = hi*VR_MAX + (hi + lo),
   // and one compare of hi + lo against VR_MAX settles the overflow count
   logic [10:0] c_hi;
   logic [31:0] c_fold;
   logic [11:0] c_k;
   logic [30:0] c_vrt;
   logic [16:0] ep_sum;
   always_comb begin
      c_hi = csum_ff[41:31];
      c_fold = {1'b0, csum_ff[30:0]} + 32'(c_hi);
      if (c_fold <= {1'b0, VR_MAX}) begin
         c_k = 12'(c_hi);
         c_vrt = c_fold[30:0];
      end else begin
         c_k = 12'(c_hi) + 12'd1;
         c_vrt = 31'(c_fold - {1'b0, VR_MAX});
      end
      ep_sum = {1'b0, tgt_ff.epoch} + 17'(c_k);
   end

   logic [5:0] dn_sat;
   logic [5:0] pn_sat;
   assign dn_sat = (dnice_ff > NICE_MAX) ? NICE_MAX : dnice_ff;
   assign pn_sat = (par_ff.nice > NICE_MAX) ? NICE_MAX : par_ff.nice;

   // updated target entry and whether it is written back
   entry_type new_in;
   logic      wr_in;
   always_comb begin
      new_in = tgt_ff;
      wr_in = 1'b0;
      case (req_ff.cmd)
         CMD_CREATE: begin
            wr_in = 1'b1;
            new_in = '{used: 1'b1, runnable: 1'b0, nice: dn_sat,
                       weight: nice_weight(dn_sat), vrt: '0, epoch: '0};
         end
         CMD_FORK: begin
            wr_in = par_ff.used;
            new_in = '{used: 1'b1, runnable: 1'b1, nice: pn_sat,
                       weight: nice_weight(pn_sat), vrt: par_ff.vrt,
                       epoch: par_ff.epoch};
         end
         CMD_NICE: begin
            wr_in = tgt_ff.used && (req_ff.nice_value <= NICE_MAX);
            new_in.nice = req_ff.nice_value;
            new_in.weight = nice_weight(req_ff.nice_value);
         end
         CMD_CHARGE: begin
            wr_in = tgt_ff.used;
            if (ep_sum > 17'(EPOCH_MAX)) begin
               new_in.epoch = EPOCH_MAX;
               new_in.vrt = VR_MAX;
            end else begin
               new_in.epoch = ep_sum[15:0];
               new_in.vrt = c_vrt;
            end
         end
         CMD_RUN: begin
            wr_in = tgt_ff.used;
            new_in.runnable = req_ff.runnable_flag;
         end
         default: wr_in = 1'b0;
      endcase
   end

   rsp_type rsp_in;
   always_comb begin
      rsp_in = '0;
      if (req_ff.cmd == CMD_NICE && req_ff.nice_value > NICE_MAX)
         rsp_in.status = ST_BAD_NICE;
      if (req_ff.cmd == CMD_PICK) begin
         rsp_in.weight_sum = (tot_ff > 24'(TW_MAX)) ? TW_MAX : tot_ff[22:0];
         rsp_in.status = found_ff ? ST_OK : ST_NONE;
         rsp_in.chosen_slot = found_ff ? best_ff : 6'd0;
      end
   end

   assign req_stall = (state_ff != S_IDLE) || rsp_v_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_v_ff <= 1'b0;
         dnice_ff <= NICE_RESET;
         pos_ff <= '0;
         wr_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) dnice_ff <= csr_data;
         if (rsp_v_ff && !rsp_stall) rsp_v_ff <= 1'b0;
         if (shift) pos_ff <= (pos_ff == PW'(TABLE_ENTRIES - 1)) ? '0 : pos_ff + PW'(1);
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  req_ff <= req_data;
                  cnt_ff <= '0;
                  tot_ff <= '0;
                  found_ff <= 1'b0;
                  best_ff <= '0;
                  tgt_ff <= '0;
                  par_ff <= '0;
                  wr_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // one rotation: capture slot/parent entries, sum, minimum;
               // the scan starts anywhere, so break ties on the slot index
               if (s_ok && 9'(pos_ff) == 9'(req_ff.slot))
                  tgt_ff <= ring[0];
               if (p_ok && 9'(pos_ff) == 9'(req_ff.parent_slot))
                  par_ff <= ring[0];
               if (ring[0].used) begin
                  tot_ff <= tot_ff + 24'(ring[0].weight);
                  if (ring[0].runnable && (!found_ff || ring[0].epoch < bep_ff ||
                      (ring[0].epoch == bep_ff && (ring[0].vrt < bvr_ff ||
                       (ring[0].vrt == bvr_ff && 6'(pos_ff) < best_ff))))) begin
                     found_ff <= 1'b1;
                     best_ff <= 6'(pos_ff);
                     bep_ff <= ring[0].epoch;
                     bvr_ff <= ring[0].vrt;
                  end
               end
               if (cnt_ff == CW'(TABLE_ENTRIES - 1)) begin
                  cnt_ff <= '0;
                  state_ff <= (req_ff.cmd == CMD_CHARGE) ? S_DIV : S_WRITE;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            S_DIV: begin
               // first cycle starts the divider; hold until its quotient lands
               if (div_done) begin
                  csum_ff <= {1'b0, div_q} + {11'd0, tgt_ff.vrt};
                  cnt_ff <= '0;
                  state_ff <= S_WRITE;
               end else begin
                  cnt_ff <= CW'(1);
               end
            end
            S_WRITE: begin
               if (cnt_ff == '0) begin
                  // build the updated entry before its pass at the head
                  new_ff <= new_in;
                  wr_ff <= wr_in;
               end
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(TABLE_ENTRIES)) state_ff <= S_RESP;
            end
            S_RESP: begin
               rsp_ff <= rsp_in;
               rsp_v_ff <= 1'b1;
               wr_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_CLK(a_one_cmd, clock, reset, (rsp_v_ff |-> req_stall), "accept while result pending")
   `ASSERT_CLK(a_rsp_from_resp, clock, reset, ($rose(rsp_v_ff) |-> $past(state_ff) == S_RESP), "result not from sequencer")
   `ASSERT_CLK(a_div_only_charge, clock, reset, (state_ff == S_DIV |-> req_ff.cmd == CMD_CHARGE), "divider without charge")
   `ASSERT_CLK(a_status_range, clock, reset, (rsp_v_ff |-> rsp_ff.status != 2'd3), "bad status code")
endmodule
`default_nettype wire

@@ rtl/wfst_cell.sv @@
// ----------------------------------------------------------------------------
// wfst_cell
// One table entry in the rotating ring; rewritten as it passes the head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wfst_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   shift,
   input  wfst_pkg::entry_type   d_in,
   output wfst_pkg::entry_type   d_out
);
   import wfst_pkg::*;
   entry_type e_ff;
   // flags reset, payload does not
   always_ff @(posedge clock) begin
      if (shift) e_ff <= d_in;
      if (reset) begin
         e_ff.used <= 1'b0;
         e_ff.runnable <= 1'b0;
      end
   end
   assign d_out = e_ff;
endmodule
`default_nettype wire

@@ rtl/wfst_div.sv @@
// ----------------------------------------------------------------------------
// wfst_div
// Radix-2 restoring divider: (delta << 10) / weight, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wfst_div (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire [30:0]  delta,
   input  wire [16:0]  weight,
   output logic        done,
   output logic [40:0] quot
);
   logic [40:0] q_ff;
   logic [17:0] r_ff;
   logic [16:0] w_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [17:0] trial;
   logic [17:0] sh;
   assign sh = {r_ff[16:0], q_ff[40]};
   assign trial = sh - {1'b0, w_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            q_ff <= {delta, 10'd0};
            r_ff <= '0;
            w_ff <= (weight == 17'd0) ? 17'd1 : weight;
            cnt_ff <= 6'd41;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!trial[17]) begin
               r_ff <= trial;
               q_ff <= {q_ff[39:0], 1'b1};
            end else begin
               r_ff <= sh;
               q_ff <= {q_ff[39:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done <= 1'b1;
            end
         end
      end
   end
   assign quot = q_ff;
endmodule
`default_nettype wire
